// ===== hw/rtl/rational_arith_unit_assert.svh =====
// assertion macros, included by rau_queue.sv
`ifndef RATIONAL_ARITH_UNIT_ASSERT_SVH
`define RATIONAL_ARITH_UNIT_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define RAU_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define RAU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hw/rtl/rau_pkg.sv =====
package rau_pkg;

   localparam int OPERAND_WIDTH = 32;
   localparam int DEN_WIDTH     = OPERAND_WIDTH - 1;
   localparam int WIDE          = 64;
   localparam int QUEUE_DEPTH   = 2;

   localparam logic [1:0] MODE_ADD = 2'd0;
   localparam logic [1:0] MODE_SUB = 2'd1;
   localparam logic [1:0] MODE_MUL = 2'd2;
   localparam logic [1:0] MODE_DIV = 2'd3;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] a_num;
      logic [30:0] a_den;
      logic [31:0] b_num;
      logic [30:0] b_den;
   } req_type;

   typedef struct packed {
      logic [63:0] result_num;
      logic [62:0] result_den;
      logic        div_by_zero;
      logic        a_less;
      logic        a_equal;
   } rsp_type;

   // classified job handed from front to back
   typedef struct packed {
      logic        neg;
      logic [63:0] mag_num;
      logic [63:0] mag_den;
      logic        err;
      logic        a_less;
      logic        a_equal;
   } job_type;

   typedef struct packed {
      logic push;
      logic full;
   } qctl_type;

endpackage

// ===== hw/rtl/rational_arith_unit.sv =====
// rational arithmetic unit: add, subtract, multiply or divide two signed
// fractions and return the result reduced by its gcd, sign on the numerator.
// the front registers the operands, forms the cross products, builds the job
// and queues it; the back runs euclid with a bit-serial remainder unit and then
// divides numerator and denominator by the gcd, also bit-serially. the queue
// holds two jobs, so the front can take a new request while the back is busy.
module rational_arith_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rau_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rau_pkg::rsp_type rsp_data
);
   import rau_pkg::*;

   logic     f_valid, q_full, q_valid, q_pop;
   job_type  f_job, q_job;
   qctl_type qctl;

   assign qctl.push = f_valid;
   assign qctl.full = q_full;

   rau_front u_front (.clock, .reset, .req_valid, .req_stall, .req_data,
      .q_full, .job_valid(f_valid), .job_data(f_job));

   rau_queue u_queue (.clock, .reset, .ctl(qctl), .in_data(f_job),
      .out_valid(q_valid), .out_pop(q_pop), .out_data(q_job), .full(q_full));

   rau_back u_back (.clock, .reset, .job_valid(q_valid), .job_pop(q_pop),
      .job_data(q_job), .rsp_valid, .rsp_stall, .rsp_data);
endmodule

// ===== hw/rtl/rau_front.sv =====
module rau_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  rau_pkg::req_type   req_data,
   input  logic               q_full,
   output logic               job_valid,
   output rau_pkg::job_type   job_data
);
   import rau_pkg::*;

   typedef enum logic [1:0] {F_IDLE, F_MUL, F_SUM, F_OUT} fstate_type;

   fstate_type       state_ff;
   logic [1:0]       mode_ff;
   logic signed [63:0] an_ff, bn_ff, ad_ff, bd_ff;
   logic signed [63:0] ca_ff, cb_ff, pn_ff, dd_ff, dbn_ff;
   job_type          job_ff, job_in;

   logic signed [63:0] an_w, bn_w, ad_w, bd_w;

   always_comb begin
      an_w = {{(WIDE-OPERAND_WIDTH){req_data.a_num[OPERAND_WIDTH-1]}},
              req_data.a_num[OPERAND_WIDTH-1:0]};
      bn_w = {{(WIDE-OPERAND_WIDTH){req_data.b_num[OPERAND_WIDTH-1]}},
              req_data.b_num[OPERAND_WIDTH-1:0]};
      ad_w = (req_data.a_den[DEN_WIDTH-1:0] == '0) ? 64'sd1
             : {{(WIDE-DEN_WIDTH){1'b0}}, req_data.a_den[DEN_WIDTH-1:0]};
      bd_w = (req_data.b_den[DEN_WIDTH-1:0] == '0) ? 64'sd1
             : {{(WIDE-DEN_WIDTH){1'b0}}, req_data.b_den[DEN_WIDTH-1:0]};
   end

   assign req_stall = (state_ff != F_IDLE);

   logic signed [63:0] num_w, den_w;
   always_comb begin
      job_in = job_ff;
      num_w = 64'sd0;
      den_w = dd_ff;
      unique case (mode_ff)
         MODE_ADD: num_w = ca_ff + cb_ff;
         MODE_SUB: num_w = ca_ff - cb_ff;
         MODE_MUL: num_w = pn_ff;
         MODE_DIV: begin
            num_w = ca_ff;
            den_w = dbn_ff;
         end
         default: num_w = 64'sd0;
      endcase
      job_in.err     = (mode_ff == MODE_DIV) && (bn_ff == 64'sd0);
      job_in.neg     = num_w[63] ^ den_w[63];
      job_in.mag_num = num_w[63] ? -num_w : num_w;
      job_in.mag_den = den_w[63] ? -den_w : den_w;
      job_in.a_less  = ca_ff < cb_ff;
      job_in.a_equal = ca_ff == cb_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         unique case (state_ff)
            F_IDLE: if (req_valid) begin
               mode_ff  <= req_data.mode;
               an_ff    <= an_w;
               bn_ff    <= bn_w;
               ad_ff    <= ad_w;
               bd_ff    <= bd_w;
               state_ff <= F_MUL;
            end
            F_MUL: begin
               // five independent products, one multiplier each
               ca_ff  <= 64'($signed(an_ff[32:0]) * $signed(bd_ff[32:0]));
               cb_ff  <= 64'($signed(bn_ff[32:0]) * $signed(ad_ff[32:0]));
               pn_ff  <= 64'($signed(an_ff[32:0]) * $signed(bn_ff[32:0]));
               dd_ff  <= 64'($signed(ad_ff[32:0]) * $signed(bd_ff[32:0]));
               dbn_ff <= 64'($signed(ad_ff[32:0]) * $signed(bn_ff[32:0]));
               state_ff <= F_SUM;
            end
            F_SUM: begin
               job_ff   <= job_in;
               state_ff <= F_OUT;
            end
            F_OUT: if (!q_full) state_ff <= F_IDLE;
            default: state_ff <= F_IDLE;
         endcase
      end
   end

   assign job_valid = (state_ff == F_OUT);
   assign job_data  = job_ff;
endmodule

// ===== hw/rtl/rau_queue.sv =====
module rau_queue (
   input  logic             clock,
   input  logic             reset,
   input  rau_pkg::qctl_type ctl,
   input  rau_pkg::job_type in_data,
   output logic             out_valid,
   input  logic             out_pop,
   output rau_pkg::job_type out_data,
   output logic             full
);
   import rau_pkg::*;
   `include "rational_arith_unit_assert.svh"

   job_type    mem_ff [QUEUE_DEPTH];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign push = ctl.push && !full;
   assign pop  = out_pop && out_valid;
   assign full = (cnt_ff == 2'(QUEUE_DEPTH));
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= in_data;
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

   `RAU_ASSERT_IMPL(a_cnt_range, clock, reset, 1'b1, cnt_ff <= 2'(QUEUE_DEPTH))
   `RAU_ASSERT_NEXT(a_push_counts, clock, reset, push && !pop, cnt_ff == $past(cnt_ff) + 2'd1)
   `RAU_ASSERT_IMPL(a_ptr_match, clock, reset, cnt_ff == 2'd0 || full, wp_ff == rp_ff)
endmodule

// ===== hw/rtl/rau_back.sv =====
module rau_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   output logic             job_pop,
   input  rau_pkg::job_type job_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rau_pkg::rsp_type rsp_data
);
   import rau_pkg::*;

   typedef enum logic [2:0] {B_IDLE, B_GCD, B_DIVN, B_DIVD, B_OUT} bstate_type;

   bstate_type  state_ff;
   job_type     job_ff;
   logic [63:0] x_ff, y_ff, g_ff, rem_ff, quo_ff, dvd_ff, qn_ff;
   logic [5:0]  bit_ff;
   logic        mod_ff;
   rsp_type     rsp_ff;

   // one restoring step: dividend bit shifted into remainder
   logic [64:0] trial;
   logic [63:0] rem_sh;
   always_comb begin
      rem_sh = {rem_ff[62:0], dvd_ff[bit_ff]};
      trial  = {1'b0, rem_sh} - {1'b0, (mod_ff ? x_ff : g_ff)};
   end

   assign job_pop   = (state_ff == B_IDLE) && job_valid;
   assign rsp_valid = (state_ff == B_OUT);
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         unique case (state_ff)
            B_IDLE: if (job_valid) begin
               job_ff   <= job_data;
               x_ff     <= job_data.mag_num;
               y_ff     <= job_data.mag_den;
               state_ff <= B_GCD;
               mod_ff   <= 1'b1;
               rem_ff   <= '0;
               dvd_ff   <= job_data.mag_den;
               bit_ff   <= 6'd63;
            end
            B_GCD: begin
               // euclid: y % x computed bit-serially, then swap
               if (x_ff == 64'd0) begin
                  g_ff     <= (y_ff == 64'd0) ? 64'd1 : y_ff;
                  mod_ff   <= 1'b0;
                  rem_ff   <= '0;
                  quo_ff   <= '0;
                  dvd_ff   <= job_ff.mag_num;
                  bit_ff   <= 6'd63;
                  state_ff <= B_DIVN;
               end else begin
                  rem_ff <= trial[64] ? rem_sh : trial[63:0];
                  bit_ff <= bit_ff - 6'd1;
                  if (bit_ff == 6'd0) begin
                     y_ff   <= x_ff;
                     x_ff   <= trial[64] ? rem_sh : trial[63:0];
                     dvd_ff <= x_ff;
                     rem_ff <= '0;
                  end
               end
            end
            B_DIVN, B_DIVD: begin
               rem_ff <= trial[64] ? rem_sh : trial[63:0];
               quo_ff <= {quo_ff[62:0], ~trial[64]};
               bit_ff <= bit_ff - 6'd1;
               if (bit_ff == 6'd0) begin
                  rem_ff <= '0;
                  quo_ff <= '0;
                  bit_ff <= 6'd63;
                  if (state_ff == B_DIVN) begin
                     qn_ff    <= {quo_ff[62:0], ~trial[64]};
                     dvd_ff   <= job_ff.mag_den;
                     state_ff <= B_DIVD;
                  end else begin
                     logic [63:0] qd;
                     qd = {quo_ff[62:0], ~trial[64]};
                     rsp_ff.div_by_zero <= job_ff.err;
                     rsp_ff.a_less      <= job_ff.a_less;
                     rsp_ff.a_equal     <= job_ff.a_equal;
                     if (job_ff.err) begin
                        rsp_ff.result_num <= '0;
                        rsp_ff.result_den <= '0;
                     end else if (qn_ff == 64'd0) begin
                        rsp_ff.result_num <= '0;
                        rsp_ff.result_den <= 63'd1;
                     end else begin
                        rsp_ff.result_num <= job_ff.neg ? -qn_ff : qn_ff;
                        rsp_ff.result_den <= qd[62:0];
                     end
                     state_ff <= B_OUT;
                  end
               end
            end
            B_OUT: if (!rsp_stall) state_ff <= B_IDLE;
            default: state_ff <= B_IDLE;
         endcase
      end
   end
endmodule
